@@ src/global_barrier_arrival_unit_top_defines.svh @@
// Assertion macros shared by the barrier arrival unit.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef GLOBAL_BARRIER_ARRIVAL_UNIT_TOP_DEFINES_SVH
`define GLOBAL_BARRIER_ARRIVAL_UNIT_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBAU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("barrier arrival unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GBAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("barrier arrival unit: next-cycle check failed");

`endif

@@ src/gbau_pkg.sv @@
`default_nettype none

package gbau_pkg;

  // Field widths of the arrival and resume transfers.
  localparam int unsigned BARRIER_ID_W  = 10;
  localparam int unsigned COUNT_W       = 5;
  localparam int unsigned CORE_ID_W     = 8;
  localparam int unsigned RESUME_CORE_W = 4;

  // Default configuration of the barrier unit.
  localparam int unsigned NUM_BARRIERS_DEF    = 8;
  localparam int unsigned SOCKETS_DEF         = 4;
  localparam int unsigned CORES_PER_GROUP_DEF = 4;

endpackage

`default_nettype wire

@@ src/gbau_arrival_if.sv @@
`default_nettype none

interface gbau_arrival_if;
  import gbau_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [BARRIER_ID_W-1:0]  barrier_id;
  logic [COUNT_W-1:0]       expected_count;
  logic [CORE_ID_W-1:0]     arriving_core;

  modport source (
    output valid, barrier_id, expected_count, arriving_core,
    input  ready
  );

  modport sink (
    input  valid, barrier_id, expected_count, arriving_core,
    output ready
  );
endinterface

`default_nettype wire

@@ src/gbau_resume_if.sv @@
`default_nettype none

interface gbau_resume_if;
  import gbau_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [RESUME_CORE_W-1:0]  resume_core;
  logic [BARRIER_ID_W-1:0]   resume_barrier;
  logic                      last_resume;

  modport source (
    output valid, resume_core, resume_barrier, last_resume,
    input  ready
  );

  modport sink (
    input  valid, resume_core, resume_barrier, last_resume,
    output ready
  );
endinterface

`default_nettype wire

@@ src/gbau_ram.sv @@
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data.
module gbau_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/global_barrier_arrival_unit_top.sv @@
`default_nettype none
// Counting barrier with one arrival mask per barrier slot. Each arrival transfer names a
// barrier, the number of distinct cores that releases it and the arriving core; the core's
// bit is set in the slot's mask (the slot being the barrier id modulo NUM_BARRIERS, the
// local core the core id modulo SOCKETS * CORES_PER_GROUP), and a repeat arrival is not
// counted twice. When the number of set bits equals the count of the arrival, one resume
// transfer per set core leaves in ascending order of local index, carrying the full barrier
// id and a flag on the last one, and the mask is cleared. The block works on one arrival at
// a time: in the idle state an arrival is taken and both quotients are formed by a
// multiplication with a constant reciprocal; in the modulo state the remainders are formed
// and the mask memory is read, and in the read state the entry is modified and written
// back. A release then steps through the local core positions up to the highest set one,
// pausing whenever the resume output register is held by a stalled sink. Masks are cleared
// at reset through one valid flag per slot, so no clearing pass is needed and the block
// accepts arrivals straight after reset.

`include "global_barrier_arrival_unit_top_defines.svh"

module global_barrier_arrival_unit_top #(
  parameter int unsigned NUM_BARRIERS    = gbau_pkg::NUM_BARRIERS_DEF,
  parameter int unsigned SOCKETS         = gbau_pkg::SOCKETS_DEF,
  parameter int unsigned CORES_PER_GROUP = gbau_pkg::CORES_PER_GROUP_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  gbau_arrival_if.sink   in_i,
  gbau_resume_if.source  out_o
);
  import gbau_pkg::*;

  // Derived sizes. The mask memory holds, per slot, a count of set bits above the mask.
  localparam int unsigned CT    = SOCKETS * CORES_PER_GROUP;
  localparam int unsigned SW    = (NUM_BARRIERS > 1) ? $clog2(NUM_BARRIERS) : 1;
  localparam int unsigned CW    = (CT > 1) ? $clog2(CT) : 1;
  localparam int unsigned CNTW  = $clog2(CT + 1);
  localparam int unsigned CMPW  = (CNTW > COUNT_W) ? CNTW : COUNT_W;
  localparam int unsigned EW    = CNTW + CT;

  // Reciprocal constants for the two modulo reductions. With a shift of sixteen the
  // rounded-up reciprocal gives the exact quotient for every id of the field widths,
  // as long as the divisors stay within their parameter ranges.
  localparam int unsigned RECIP_SH   = 16;
  localparam int unsigned SLOT_RECIP = ((32'd1 << RECIP_SH) + NUM_BARRIERS - 1) / NUM_BARRIERS;
  localparam int unsigned CORE_RECIP = ((32'd1 << RECIP_SH) + CT - 1) / CT;
  localparam int unsigned BPW        = BARRIER_ID_W + RECIP_SH;
  localparam int unsigned CPW        = CORE_ID_W + RECIP_SH;
  localparam logic [BARRIER_ID_W-1:0] NB_W = BARRIER_ID_W'(NUM_BARRIERS);
  localparam logic [CORE_ID_W-1:0]    CT_W = CORE_ID_W'(CT);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [BARRIER_ID_W-1:0] bid_q, bid_d;
  logic [COUNT_W-1:0]      want_q, want_d;
  logic [CORE_ID_W-1:0]    core_q, core_d;
  logic [BARRIER_ID_W-1:0] bid_quot_q, bid_quot_d;
  logic [CORE_ID_W-1:0]    core_quot_q, core_quot_d;
  logic [SW-1:0]           slot_q, slot_d;
  logic [CW-1:0]           local_q, local_d;
  logic [CT-1:0]           mask_q, mask_d;
  logic [CNTW-1:0]         remain_q, remain_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic [NUM_BARRIERS-1:0] valid_q, valid_d;

  logic                     out_valid_q, out_valid_d;
  logic [RESUME_CORE_W-1:0] out_core_q, out_core_d;
  logic [BARRIER_ID_W-1:0]  out_bid_q, out_bid_d;
  logic                     out_last_q, out_last_d;

  // Memory port signals.
  logic          ram_we, ram_re;
  logic [SW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  // Modulo reduction: the quotients come from the arriving transfer, the remainders
  // from the captured ids in the cycle after.
  logic [BPW-1:0]          bid_prod;
  logic [CPW-1:0]          core_prod;
  logic [BARRIER_ID_W-1:0] slot_full;
  logic [CORE_ID_W-1:0]    local_full;

  always_comb begin
    bid_prod   = BPW'(32'(in_i.barrier_id) * SLOT_RECIP);
    core_prod  = CPW'(32'(in_i.arriving_core) * CORE_RECIP);
    slot_full  = bid_q - bid_quot_q * NB_W;
    local_full = core_q - core_quot_q * CT_W;
  end

  // Read-modify of the slot entry. A slot whose flag is clear reads as an empty mask.
  logic [EW-1:0]   entry;
  logic [CT-1:0]   old_mask, new_mask, core_bit;
  logic [CNTW-1:0] old_cnt, new_cnt;
  logic            repeat_hit, release_hit;

  always_comb begin
    entry       = valid_q[slot_q] ? ram_rdata : '0;
    old_mask    = entry[CT-1:0];
    old_cnt     = entry[EW-1:CT];
    core_bit    = CT'(1) << local_q;
    repeat_hit  = |(old_mask & core_bit);
    new_mask    = old_mask | core_bit;
    new_cnt     = repeat_hit ? old_cnt : old_cnt + CNTW'(1);
    release_hit = (CMPW'(new_cnt) == CMPW'(want_q));
  end

  // The resume register may be loaded when it is empty or is being drained this cycle.
  logic        slot_free;
  logic [31:0] idx_ext;

  assign slot_free = !out_valid_q || out_o.ready;
  assign idx_ext   = 32'(idx_q);

  always_comb begin
    state_d     = state_q;
    bid_d       = bid_q;
    want_d      = want_q;
    core_d      = core_q;
    bid_quot_d  = bid_quot_q;
    core_quot_d = core_quot_q;
    slot_d      = slot_q;
    local_d     = local_q;
    mask_d      = mask_q;
    remain_d    = remain_q;
    idx_d       = idx_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q;
    out_core_d  = out_core_q;
    out_bid_d   = out_bid_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = slot_q;
    ram_raddr   = slot_full[SW-1:0];
    ram_wdata   = {new_cnt, new_mask};

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          bid_d       = in_i.barrier_id;
          want_d      = in_i.expected_count;
          core_d      = in_i.arriving_core;
          bid_quot_d  = bid_prod[BPW-1:RECIP_SH];
          core_quot_d = core_prod[CPW-1:RECIP_SH];
          state_d     = S_MOD;
        end
      end
      S_MOD: begin
        slot_d  = slot_full[SW-1:0];
        local_d = local_full[CW-1:0];
        ram_re  = 1'b1;
        state_d = S_READ;
      end
      S_READ: begin
        ram_we          = 1'b1;
        valid_d[slot_q] = 1'b1;
        if (release_hit) begin
          ram_wdata = '0;
          mask_d    = new_mask;
          remain_d  = new_cnt;
          idx_d     = '0;
          state_d   = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          if (mask_q[0]) begin
            out_valid_d = 1'b1;
            out_core_d  = idx_ext[RESUME_CORE_W-1:0];
            out_bid_d   = bid_q;
            out_last_d  = (remain_q == CNTW'(1));
            remain_d    = remain_q - CNTW'(1);
            if (remain_q == CNTW'(1)) begin
              state_d = S_IDLE;
            end
          end
          mask_d = mask_q >> 1;
          idx_d  = idx_q + CW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bid_q       <= bid_d;
    want_q      <= want_d;
    core_q      <= core_d;
    bid_quot_q  <= bid_quot_d;
    core_quot_q <= core_quot_d;
    slot_q      <= slot_d;
    local_q     <= local_d;
    mask_q      <= mask_d;
    remain_q    <= remain_d;
    idx_q       <= idx_d;
    out_core_q  <= out_core_d;
    out_bid_q   <= out_bid_d;
    out_last_q  <= out_last_d;
  end

  // Mask memory: a count of set bits and the arrival mask per slot.
  gbau_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_BARRIERS)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.resume_core    = out_core_q;
  assign out_o.resume_barrier = out_bid_q;
  assign out_o.last_resume    = out_last_q;

  // An accepted arrival always starts the modulo reduction.
  `GBAU_ASSERT_NEXT(a_accept_starts_mod, in_i.valid && in_i.ready, state_q == S_MOD)
  // While resumes are being emitted, some are still owed and some mask bit remains.
  `GBAU_ASSERT_SAME(a_emit_owes_resume, state_q == S_EMIT, remain_q != '0)
  `GBAU_ASSERT_SAME(a_emit_mask_live, state_q == S_EMIT, mask_q != '0)

endmodule

`default_nettype wire
